>>> sv/fat_entry_writer_defines.svh
// ---------------------------------------------------------------------------
// FAT entry writer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FAT_ENTRY_WRITER_DEFINES_SVH
`define FAT_ENTRY_WRITER_DEFINES_SVH

// same-cycle implication
`define FATW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fatw check failed");

// next-cycle implication
`define FATW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fatw check failed");

`endif

>>> sv/fatw_pkg.sv
// ---------------------------------------------------------------------------
// fatw_pkg
// Types and constants shared by the FAT entry writer modules.
// ---------------------------------------------------------------------------
package fatw_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam int SECT_SHIFT   = $clog2(SECTOR_BYTES);
	localparam int BYTE_W       = 30;                 // cluster * 4 fits in 30 bits
	localparam int NSECT_W      = BYTE_W - SECT_SHIFT;
	localparam int FSECT_W      = 24;
	localparam int CMP_W        = (NSECT_W > FSECT_W) ? NSECT_W : FSECT_W;

	// configuration register indexes
	localparam logic [1:0] CFG_FAT_MODE      = 2'd0;
	localparam logic [1:0] CFG_MAX_CLUSTERS  = 2'd1;
	localparam logic [1:0] CFG_FAT_SECTORS   = 2'd2;
	localparam logic [1:0] CFG_FAT_START_LBA = 2'd3;

	// table formats
	localparam logic [1:0] MODE_FAT12     = 2'd0;
	localparam logic [1:0] MODE_FAT16     = 2'd1;
	localparam logic [1:0] MODE_FAT32_NOP = 2'd2;
	localparam logic [1:0] MODE_FAT32_LBA = 2'd3;

	// result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [1:0] ST_BEYOND   = 2'd2;

	// FAT12 byte/nibble masks, FAT12/16/32 entry masks
	localparam logic [31:0] MASK_HI_NIB  = 32'h0000_00f0;
	localparam logic [31:0] MASK_LO_NIB  = 32'h0000_000f;
	localparam logic [31:0] MASK_BYTE    = 32'h0000_00ff;
	localparam logic [31:0] MASK_12_ODD  = 32'h0000_fff0;
	localparam logic [31:0] MASK_12_EVEN = 32'h0000_0fff;
	localparam logic [31:0] MASK_16      = 32'h0000_ffff;
	localparam logic [31:0] MASK_32      = 32'hffff_ffff;

	typedef struct packed {
		logic [1:0]  fat_mode;
		logic [27:0] max_clusters;
		logic [23:0] fat_sectors;
	} cfg_t;

	// one decoded request: up to four write commands
	typedef struct packed {
		logic [1:0]         status;
		logic               zero;      // error or no-op: single zero-mask result
		logic               split;     // FAT12 entry across a sector edge
		logic [1:0]         nlast;     // index of the final result
		logic [NSECT_W-1:0] nsect;
		logic [8:0]         off;
		logic [31:0]        d0;
		logic [31:0]        m0;
		logic [31:0]        d1;
		logic [31:0]        m1;
	} job_t;

	typedef struct packed {
		logic [31:0] lba;
		logic [8:0]  off;
		logic [31:0] data;
		logic [31:0] mask;
		logic [1:0]  status;
		logic        last;
	} res_t;

endpackage

>>> sv/fatw_decode.sv
// ---------------------------------------------------------------------------
// fatw_decode
// Maps a cluster and link value to table sector, offset, data and masks.
// ---------------------------------------------------------------------------
module fatw_decode
	import fatw_pkg::*;
(
	input  logic [27:0] cluster,
	input  logic [31:0] next_value,
	input  cfg_t        cfg,
	output job_t        job
);

	logic [BYTE_W-1:0]     byte_no;
	logic [NSECT_W-1:0]    nsect;
	logic [SECT_SHIFT-1:0] off_full;
	logic [11:0]           v12;
	logic                  too_big;
	logic                  beyond;
	logic                  odd;
	logic                  split;

	always_comb begin
		case (cfg.fat_mode)
			// cluster * 3 / 2 == cluster + cluster / 2
			MODE_FAT12: byte_no = BYTE_W'(cluster) + BYTE_W'(cluster[27:1]);
			MODE_FAT16: byte_no = BYTE_W'({cluster, 1'b0});
			default:    byte_no = {cluster, 2'b00};
		endcase
	end

	assign nsect    = byte_no[BYTE_W-1:SECT_SHIFT];
	assign off_full = byte_no[SECT_SHIFT-1:0];
	assign too_big  = cluster > cfg.max_clusters;
	assign beyond   = CMP_W'(nsect) >= CMP_W'(cfg.fat_sectors);
	assign v12      = next_value[11:0];
	assign odd      = cluster[0];
	assign split    = (cfg.fat_mode == MODE_FAT12) && (&off_full);

	always_comb begin
		job       = '0;
		job.nsect = nsect;
		job.off   = byte_no[8:0];
		if (too_big) begin
			job.status = ST_TOO_BIG;
			job.zero   = 1'b1;
		end else if (cfg.fat_mode == MODE_FAT32_NOP) begin
			job.status = ST_OK;
			job.zero   = 1'b1;
		end else if (beyond) begin
			job.status = ST_BEYOND;
			job.zero   = 1'b1;
		end else begin
			job.status = ST_OK;
			job.split  = split;
			job.nlast  = split ? 2'd3 : 2'd1;
		end

		case (cfg.fat_mode)
			MODE_FAT12: begin
				if (split) begin
					// standard layout across the edge
					if (odd) begin
						job.d0 = 32'({v12[3:0], 4'h0});
						job.m0 = MASK_HI_NIB;
						job.d1 = 32'(v12[11:4]);
						job.m1 = MASK_BYTE;
					end else begin
						job.d0 = 32'(v12[7:0]);
						job.m0 = MASK_BYTE;
						job.d1 = 32'(v12[11:8]);
						job.m1 = MASK_LO_NIB;
					end
				end else if (odd) begin
					job.d0 = 32'({v12, 4'h0});
					job.m0 = MASK_12_ODD;
				end else begin
					job.d0 = 32'(v12);
					job.m0 = MASK_12_EVEN;
				end
			end
			MODE_FAT16: begin
				job.d0 = 32'(next_value[15:0]);
				job.m0 = MASK_16;
			end
			default: begin
				job.d0 = next_value;
				job.m0 = MASK_32;
			end
		endcase
	end

endmodule

>>> sv/fatw_seq.sv
// ---------------------------------------------------------------------------
// fatw_seq
// Holds a decoded request, issuing its writes one per cycle unless stalled.
// ---------------------------------------------------------------------------
`include "fat_entry_writer_defines.svh"

module fatw_seq
	import fatw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  job_t        req,
	output logic        take,
	input  logic [31:0] start_lba,
	input  logic [31:0] copy2_base,
	input  logic        out_stall,
	output logic        out_valid,
	output res_t        res
);

	logic        job_v_q;
	job_t        job_q;
	logic [1:0]  idx_q;
	logic        out_v_q;
	res_t        out_q;
	logic        out_free;
	logic        advance;
	logic        is_last;
	logic        copy2;
	logic        second;
	logic [31:0] base;
	res_t        nxt;

	assign out_free = !out_v_q || !out_stall;
	assign advance  = job_v_q && out_free;
	assign is_last  = (idx_q == job_q.nlast);
	assign take     = !job_v_q || (advance && is_last);

	// split order: c1 n, c1 n+1, c2 n, c2 n+1
	assign copy2  = job_q.split ? idx_q[1] : idx_q[0];
	assign second = job_q.split & idx_q[0];
	assign base   = copy2 ? copy2_base : start_lba;

	always_comb begin
		nxt        = '0;
		nxt.status = job_q.status;
		nxt.last   = is_last;
		if (!job_q.zero) begin
			nxt.lba  = base + 32'(job_q.nsect) + 32'(second);
			nxt.off  = second ? 9'd0 : job_q.off;
			nxt.data = second ? job_q.d1 : job_q.d0;
			nxt.mask = second ? job_q.m1 : job_q.m0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			idx_q   <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				job_v_q <= req_valid;
				idx_q   <= 2'd0;
			end else if (advance) begin
				idx_q <= idx_q + 2'd1;
			end
			if (out_free)
				out_v_q <= job_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			job_q <= req;
		if (advance)
			out_q <= nxt;
	end

	assign out_valid = out_v_q;
	assign res       = out_q;

	`FATW_ASSERT_NOW(a_idx_range, job_v_q && !job_q.split, !idx_q[1])
	`FATW_ASSERT_NOW(a_zero_single, job_v_q && job_q.zero, job_q.nlast == 2'd0)
	`FATW_ASSERT_NOW(a_err_empty, out_v_q && out_q.status != ST_OK,
		out_q.last && out_q.mask == 32'd0)
	`FATW_ASSERT_NEXT(a_no_gap, out_v_q && !out_stall && !out_q.last, out_v_q)

endmodule

>>> sv/fat_entry_writer.sv
// ---------------------------------------------------------------------------
// fat_entry_writer
// Turns a cluster link update into masked sector writes for both FAT copies.
// ---------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  request  | in_valid / in_stall      | cluster, next_value
//  result   | out_valid / out_stall    | sector_lba, byte_offset, write_data,
//           |                          | write_mask, status, last
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A request is registered, decoded, then parked in the command register,
// which issues one result per cycle into the output register unless
// out_stall holds it: 1 result for an error or FAT32 no-op, 2 normally,
// 4 for a FAT12 entry across a sector edge. Each request passes the input
// register, the command register and then the output register.
// Reset clears all valid flags and config registers; no clearing pass.
// out_stall holds the output register and backs up into in_stall.
// cfg_ready is always high.
module fat_entry_writer
	import fatw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [27:0] cluster,
	input  logic [31:0] next_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sector_lba,
	output logic [8:0]  byte_offset,
	output logic [31:0] write_data,
	output logic [31:0] write_mask,
	output logic [1:0]  status,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t        cfg_q;
	logic [31:0] start_lba_q;
	logic [31:0] copy2_base_q;
	logic        valid_s1;
	logic [27:0] cluster_s1;
	logic [31:0] value_s1;
	job_t        job;
	logic        take;
	res_t        res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= '0;
			start_lba_q  <= '0;
			copy2_base_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_FAT_MODE:      cfg_q.fat_mode     <= cfg_data[1:0];
					CFG_MAX_CLUSTERS:  cfg_q.max_clusters <= cfg_data[27:0];
					CFG_FAT_SECTORS:   cfg_q.fat_sectors  <= cfg_data[23:0];
					CFG_FAT_START_LBA: start_lba_q        <= cfg_data;
					default: ;
				endcase
			end
			// second copy base; user must let it settle while idle (unenforced)
			copy2_base_q <= start_lba_q + 32'(cfg_q.fat_sectors);
		end
	end

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cluster_s1 <= cluster;
			value_s1   <= next_value;
		end
	end

	fatw_decode u_decode (
		.cluster    (cluster_s1),
		.next_value (value_s1),
		.cfg        (cfg_q),
		.job        (job)
	);

	fatw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (valid_s1),
		.req        (job),
		.take       (take),
		.start_lba  (start_lba_q),
		.copy2_base (copy2_base_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.res        (res)
	);

	assign sector_lba  = res.lba;
	assign byte_offset = res.off;
	assign write_data  = res.data;
	assign write_mask  = res.mask;
	assign status      = res.status;
	assign last        = res.last;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for fat_entry_writer. A local model of the allocation
// table layout predicts the masked sector writes for each accepted request;
// a monitor checks every result against the oldest prediction. Directed
// cases per table format, then randomized traffic over several formats.
// ---------------------------------------------------------------------------
module tb_top;
	import fatw_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [27:0] cluster;
	logic [31:0] next_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] sector_lba;
	logic [8:0]  byte_offset;
	logic [31:0] write_data;
	logic [31:0] write_mask;
	logic [1:0]  status;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// local copy of the table geometry
	logic [1:0]  tbl_mode    = MODE_FAT12;
	logic [27:0] tbl_max_clu = '0;
	logic [23:0] tbl_sectors = '0;
	logic [31:0] tbl_start   = '0;

	res_t pending_writes[$];
	int   mismatch_cnt = 0;
	int   stall_left   = 0;
	bit   no_idle      = 1'b0;

	fat_entry_writer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cluster     (cluster),
		.next_value  (next_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sector_lba  (sector_lba),
		.byte_offset (byte_offset),
		.write_data  (write_data),
		.write_mask  (write_mask),
		.status      (status),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void queue_write(input logic [31:0] lba, input logic [8:0] off,
			input logic [31:0] data, input logic [31:0] mask, input logic [1:0] st,
			input logic fin);
		res_t r;
		r.lba    = lba;
		r.off    = off;
		r.data   = data;
		r.mask   = mask;
		r.status = st;
		r.last   = fin;
		pending_writes.push_back(r);
	endfunction

	function automatic void predict_entry_writes(input logic [27:0] clu,
			input logic [31:0] val);
		logic [63:0] byte_no;
		logic [63:0] nsect;
		logic [8:0]  off;
		logic [31:0] lba1, lba2, d0, m0, d1, m1;
		logic [11:0] v;
		if (clu > tbl_max_clu) begin
			queue_write('0, '0, '0, '0, ST_TOO_BIG, 1'b1);
			return;
		end
		if (tbl_mode == MODE_FAT32_NOP) begin
			queue_write('0, '0, '0, '0, ST_OK, 1'b1);
			return;
		end
		case (tbl_mode)
			MODE_FAT12: byte_no = (64'(clu) * 3) >> 1;
			MODE_FAT16: byte_no = 64'(clu) * 2;
			default:    byte_no = 64'(clu) * 4;
		endcase
		nsect = byte_no / SECTOR_BYTES;
		if (nsect >= 64'(tbl_sectors)) begin
			queue_write('0, '0, '0, '0, ST_BEYOND, 1'b1);
			return;
		end
		off  = 9'(byte_no % SECTOR_BYTES);
		lba1 = tbl_start + nsect[31:0];
		lba2 = lba1 + 32'(tbl_sectors);
		v    = val[11:0];
		// FAT12 entry straddling a sector edge: low part in sector n, rest in n+1
		if (tbl_mode == MODE_FAT12 && off == 9'(SECTOR_BYTES - 1)) begin
			if (clu[0]) begin
				d0 = {24'b0, v[3:0], 4'b0};
				m0 = MASK_HI_NIB;
				d1 = {24'b0, v[11:4]};
				m1 = MASK_BYTE;
			end else begin
				d0 = {24'b0, v[7:0]};
				m0 = MASK_BYTE;
				d1 = {28'b0, v[11:8]};
				m1 = MASK_LO_NIB;
			end
			queue_write(lba1, off, d0, m0, ST_OK, 1'b0);
			queue_write(lba1 + 32'd1, '0, d1, m1, ST_OK, 1'b0);
			queue_write(lba2, off, d0, m0, ST_OK, 1'b0);
			queue_write(lba2 + 32'd1, '0, d1, m1, ST_OK, 1'b1);
			return;
		end
		case (tbl_mode)
			MODE_FAT12: begin
				if (clu[0]) begin
					d0 = {16'b0, v, 4'b0};
					m0 = MASK_12_ODD;
				end else begin
					d0 = {20'b0, v};
					m0 = MASK_12_EVEN;
				end
			end
			MODE_FAT16: begin
				d0 = {16'b0, val[15:0]};
				m0 = MASK_16;
			end
			default: begin
				d0 = val;
				m0 = MASK_32;
			end
		endcase
		queue_write(lba1, off, d0, m0, ST_OK, 1'b0);
		queue_write(lba2, off, d0, m0, ST_OK, 1'b1);
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
			mismatch_cnt++;
		end
	endfunction

	// result monitor and output back-pressure
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (out_stall) begin
				if (stall_left > 1) begin
					stall_left--;
				end else begin
					stall_left = 0;
					out_stall <= 1'b0;
				end
			end else if (out_valid) begin
				if (pending_writes.size() == 0) begin
					$display("%0t: unexpected write, expected none, got lba 0x%0h status %0d",
						$time, sector_lba, status);
					mismatch_cnt++;
				end else begin
					want = pending_writes.pop_front();
					check_field("sector_lba", want.lba, sector_lba);
					check_field("byte_offset", 32'(want.off), 32'(byte_offset));
					check_field("write_data", want.data, write_data);
					check_field("write_mask", want.mask, write_mask);
					check_field("status", 32'(want.status), 32'(status));
					check_field("last", 32'(want.last), 32'(last));
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 4);
				if (stall_left != 0)
					out_stall <= 1'b1;
			end
		end
	end

	task automatic send_link(input logic [27:0] clu, input logic [31:0] val);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cluster    <= clu;
		next_value <= val;
		do
			@(posedge clk);
		while (in_stall);
		predict_entry_writes(clu, val);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// writes all four registers back to back; upper bits carry junk
	task automatic set_format(input logic [1:0] mode, input logic [27:0] maxc,
			input logic [23:0] fsect, input logic [31:0] start);
		logic [1:0]  regs[4];
		logic [31:0] vals[4];
		logic [31:0] junk;
		junk    = $urandom();
		regs[0] = CFG_FAT_MODE;
		regs[1] = CFG_MAX_CLUSTERS;
		regs[2] = CFG_FAT_SECTORS;
		regs[3] = CFG_FAT_START_LBA;
		vals[0] = {junk[31:2], mode};
		vals[1] = {junk[31:28], maxc};
		vals[2] = {junk[31:24], fsect};
		vals[3] = start;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (regs[i])
				CFG_FAT_MODE:      tbl_mode    = vals[i][1:0];
				CFG_MAX_CLUSTERS:  tbl_max_clu = vals[i][27:0];
				CFG_FAT_SECTORS:   tbl_sectors = vals[i][23:0];
				CFG_FAT_START_LBA: tbl_start   = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// reset geometry: no sectors and max cluster 0
	task automatic test_reset_state();
		send_link(28'd0, 32'hffff_ffff);
		send_link(28'hfff_ffff, 32'h0);
		wait_results_done();
	endtask

	task automatic test_fat12();
		set_format(MODE_FAT12, 28'hfff_ffff, 24'd2, 32'h0000_1000);
		send_link(28'd0, 32'hffff_ffff);
		send_link(28'd1, 32'hffff_ffff);
		send_link(28'd341, 32'h0000_0abc);     // odd entry across sectors 0/1
		send_link(28'd682, 32'hffff_f123);     // even entry at last table sector
		send_link(28'd1364, 32'h0000_0555);    // beyond table
		send_link(28'd340, 32'h0000_0000);
		wait_results_done();
	endtask

	task automatic test_fat16();
		set_format(MODE_FAT16, 28'd1000, 24'd8, 32'hffff_fff0);
		send_link(28'd0, 32'h1234_5678);
		send_link(28'd1000, 32'hffff_ffff);
		send_link(28'd255, 32'h0000_a5a5);
		send_link(28'd1001, 32'hffff_ffff);   // too large
		wait_results_done();
	endtask

	task automatic test_fat32_nop();
		set_format(MODE_FAT32_NOP, 28'd100, 24'd1, 32'h0000_0055);
		send_link(28'd100, 32'hdead_beef);
		send_link(28'd101, 32'hdead_beef);
		send_link(28'd0, 32'h0);
		wait_results_done();
	endtask

	task automatic test_fat32_lba();
		set_format(MODE_FAT32_LBA, 28'hfff_ffff, 24'hff_ffff, 32'hffff_ffff);
		send_link(28'hfff_ffff, 32'hffff_ffff);
		send_link(28'd0, 32'h0);
		send_link(28'd127, 32'h8000_0001);
		send_link(28'd128, 32'h7fff_fffe);
		wait_results_done();
		set_format(MODE_FAT32_LBA, 28'hfff_ffff, 24'd1, 32'h0);
		send_link(28'd128, 32'h1111_1111);
		send_link(28'd127, 32'h2222_2222);
		wait_results_done();
	endtask

	task automatic test_random_traffic();
		logic [1:0]  mode;
		logic [23:0] fsect;
		logic [27:0] maxc;
		logic [27:0] clu;
		logic [31:0] val;
		logic [63:0] cap;
		int          pick;
		for (int phase = 0; phase < 6; phase++) begin
			mode = 2'($urandom_range(0, 3));
			pick = $urandom_range(0, 7);
			if (pick == 0)
				fsect = 24'hff_ffff;
			else if (pick == 1)
				fsect = 24'($urandom);
			else
				fsect = 24'($urandom_range(1, 8));
			cap = 64'(fsect) * ((mode == MODE_FAT12) ? 341 : (mode == MODE_FAT16) ? 256 : 128)
				+ $urandom_range(0, 16);
			if ($urandom_range(0, 3) == 0)
				maxc = 28'($urandom);
			else
				maxc = (cap > 64'h0fff_ffff) ? 28'hfff_ffff : cap[27:0];
			if (phase == 0) begin
				// widest geometry, second copy may wrap the sector address
				mode  = MODE_FAT12;
				fsect = 24'hff_ffff;
				maxc  = 28'hfff_ffff;
			end
			set_format(mode, maxc, fsect, $urandom());
			no_idle = (phase == 2);
			for (int n = 0; n < 20; n++) begin
				pick = $urandom_range(0, 7);
				if (pick == 0)
					clu = 28'($urandom);
				else if (pick == 1)
					clu = 28'($urandom_range(0, (maxc > 28'hfff_fff0) ? 28'hfff_ffff
						: maxc + 8));
				else if (pick < 4 && tbl_mode == MODE_FAT12)
					clu = 28'($urandom_range(0, maxc / 1024)) * 28'd1024
						+ ($urandom_range(0, 1) ? 28'd341 : 28'd682);
				else
					clu = 28'($urandom_range(0, maxc));
				pick = $urandom_range(0, 7);
				val  = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom();
				send_link(clu, val);
				if (phase == 3 && n == 10)
					wait_results_done();
			end
			wait_results_done();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		cluster    <= '0;
		next_value <= '0;
		out_stall  <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_FAT_MODE;
		cfg_data   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_fat12();
		test_fat16();
		test_fat32_nop();
		test_fat32_lba();
		test_random_traffic();
		wait_results_done();
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/fatw_pkg.sv
sv/fatw_decode.sv
sv/fatw_seq.sv
sv/fat_entry_writer.sv
tb/tb_top.sv
